### rtl/core/assert_macros.svh
// assertion macros shared by the core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/mr_pkg.sv
// package: widths, base table, state type and multiplier request types
package mr_pkg;

  localparam int WORD_BITS  = 64;
  localparam int CNT_W      = $clog2(WORD_BITS);
  localparam int R_W        = $clog2(WORD_BITS + 1);
  localparam int BASE_COUNT = 12;
  localparam int IDX_W      = $clog2(BASE_COUNT);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECOMP,
    ST_BASE,
    ST_REDUCE,
    ST_POW_STEP,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_CHECK,
    ST_SQ_STEP,
    ST_SQ_WAIT,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  go;
    word_t a;
    word_t b;
    word_t m;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_rsp_t;

  // fixed witness bases, in order
  function automatic word_t base_of(input logic [IDX_W-1:0] idx);
    word_t v;
    case (idx)
      IDX_W'(0):  v = WORD_BITS'(2);
      IDX_W'(1):  v = WORD_BITS'(3);
      IDX_W'(2):  v = WORD_BITS'(5);
      IDX_W'(3):  v = WORD_BITS'(7);
      IDX_W'(4):  v = WORD_BITS'(11);
      IDX_W'(5):  v = WORD_BITS'(13);
      IDX_W'(6):  v = WORD_BITS'(17);
      IDX_W'(7):  v = WORD_BITS'(19);
      IDX_W'(8):  v = WORD_BITS'(23);
      IDX_W'(9):  v = WORD_BITS'(29);
      IDX_W'(10): v = WORD_BITS'(31);
      IDX_W'(11): v = WORD_BITS'(37);
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/miller_rabin_prime_test.sv
// top level: deterministic miller-rabin sequencer around a shared modular multiplier
//
//  channel | ports                  | transfer
//  --------+------------------------+--------------------------------------
//  input   | start, busy, candidate | edge with start high and busy low
//  result  | done, is_prime         | edge ending the single cycle done is high
//
// one candidate at a time; busy stays high from the accepting edge until the
// cycle after done. each modular product runs bit-serially on the shared
// multiplier, and a base needs up to about 2*64 products for the power plus
// r-1 squarings; small or even candidates finish far sooner. zero and one go
// straight from the idle state to the done state.
// reset is synchronous and returns the sequencer to idle; the receiver cannot
// stall, so done is never held.
module miller_rabin_prime_test (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] candidate,
  output logic        done,
  output logic        is_prime
);
  import mr_pkg::*;
  `include "assert_macros.svh"

  state_t           state, state_next;
  word_t            n, n_next;
  word_t            nm1, nm1_next;
  word_t            d, d_next;
  word_t            e, e_next;
  word_t            base, base_next;
  word_t            acc, acc_next;
  logic [R_W-1:0]   r, r_next;
  logic [R_W-1:0]   j, j_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             verdict, verdict_next;
  mul_req_t         mreq;
  mul_rsp_t         mrsp;
  word_t            cand_w;

  assign cand_w = candidate[WORD_BITS-1:0];

  mr_mulmod u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers need no reset
  always_ff @(posedge clk) begin
    n       <= n_next;
    nm1     <= nm1_next;
    d       <= d_next;
    e       <= e_next;
    base    <= base_next;
    acc     <= acc_next;
    r       <= r_next;
    j       <= j_next;
    idx     <= idx_next;
    verdict <= verdict_next;
  end

  always_comb begin
    state_next   = state;
    n_next       = n;
    nm1_next     = nm1;
    d_next       = d;
    e_next       = e;
    base_next    = base;
    acc_next     = acc;
    r_next       = r;
    j_next       = j;
    idx_next     = idx;
    verdict_next = verdict;
    mreq.go      = 1'b0;
    mreq.a       = base;
    mreq.b       = acc;
    mreq.m       = n;
    case (state)
      ST_IDLE: begin
        if (start) begin
          n_next   = cand_w;
          nm1_next = cand_w - WORD_BITS'(1);
          d_next   = cand_w - WORD_BITS'(1);
          r_next   = '0;
          if (cand_w[WORD_BITS-1:1] == '0) begin
            // zero and one are not prime
            verdict_next = 1'b0;
            state_next   = ST_DONE;
          end else begin
            state_next = ST_DECOMP;
          end
        end
      end
      ST_DECOMP: begin
        // strip factors of two from n-1, one per cycle
        if (!d[0]) begin
          d_next = d >> 1;
          r_next = r + R_W'(1);
        end else begin
          idx_next   = '0;
          state_next = ST_BASE;
        end
      end
      ST_BASE: begin
        if (base_of(idx) == n) begin
          verdict_next = 1'b1;
          state_next   = ST_DONE;
        end else begin
          base_next  = base_of(idx);
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        // base mod n by repeated subtraction, only for tiny n
        if (base >= n) begin
          base_next = base - n;
        end else begin
          acc_next   = WORD_BITS'(1);
          e_next     = d;
          state_next = ST_POW_STEP;
        end
      end
      ST_POW_STEP: begin
        if (e == '0) begin
          state_next = ST_CHECK;
        end else if (e[0]) begin
          mreq.go    = 1'b1;
          state_next = ST_POW_MUL;
        end else begin
          mreq.go    = 1'b1;
          mreq.b     = base;
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_MUL: begin
        if (mrsp.done) begin
          acc_next   = mrsp.prod;
          mreq.go    = 1'b1;
          mreq.b     = base;
          state_next = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        if (mrsp.done) begin
          base_next  = mrsp.prod;
          e_next     = e >> 1;
          state_next = ST_POW_STEP;
        end
      end
      ST_CHECK: begin
        if ((acc == WORD_BITS'(1)) || (acc == nm1)) begin
          state_next = ST_NEXT;
        end else begin
          j_next     = R_W'(1);
          state_next = ST_SQ_STEP;
        end
      end
      ST_SQ_STEP: begin
        if (j < r) begin
          mreq.go    = 1'b1;
          mreq.a     = acc;
          state_next = ST_SQ_WAIT;
        end else begin
          // no square reached n-1: composite
          verdict_next = 1'b0;
          state_next   = ST_DONE;
        end
      end
      ST_SQ_WAIT: begin
        if (mrsp.done) begin
          acc_next = mrsp.prod;
          if (mrsp.prod == nm1) begin
            state_next = ST_NEXT;
          end else begin
            j_next     = j + R_W'(1);
            state_next = ST_SQ_STEP;
          end
        end
      end
      ST_NEXT: begin
        if (idx == IDX_W'(BASE_COUNT - 1)) begin
          verdict_next = 1'b1;
          state_next   = ST_DONE;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = ST_BASE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_DONE);
  assign is_prime = verdict;

  `ASSERT_NEXT(a_done_then_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_accept_then_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMPLIES(a_mul_only_when_busy, clk, rst, mreq.go, busy)

endmodule

### rtl/core/mr_mulmod.sv
// bit-serial modular multiplier: one modular double or add per cycle
module mr_mulmod (
  input  logic             clk,
  input  logic             rst,
  input  mr_pkg::mul_req_t req,
  output mr_pkg::mul_rsp_t rsp
);
  import mr_pkg::*;
  `include "assert_macros.svh"

  word_t            acc;
  word_t            a;
  word_t            m;
  word_t            b_sh;
  logic [CNT_W-1:0] cnt;
  logic             phase;
  logic             active;
  logic             done;

  // (x + y) mod m for x, y below m
  function automatic word_t add_mod(input word_t x, input word_t y, input word_t md);
    logic [WORD_BITS:0] s;
    logic [WORD_BITS:0] t;
    s = {1'b0, x} + {1'b0, y};
    t = s - {1'b0, md};
    return (s >= {1'b0, md}) ? t[WORD_BITS-1:0] : s[WORD_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        active <= 1'b1;
      end else if (active && phase && (cnt == '0)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      a     <= req.a;
      b_sh  <= req.b;
      m     <= req.m;
      acc   <= '0;
      cnt   <= CNT_W'(WORD_BITS - 1);
      phase <= 1'b0;
    end else if (active) begin
      if (!phase) begin
        acc   <= add_mod(acc, acc, m);
        phase <= 1'b1;
      end else begin
        if (b_sh[WORD_BITS-1]) begin
          acc <= add_mod(acc, a, m);
        end
        b_sh  <= b_sh << 1;
        cnt   <= cnt - CNT_W'(1);
        phase <= 1'b0;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

  `ASSERT_NEVER(a_go_while_active, clk, rst, req.go && active)
  `ASSERT_IMPLIES(a_done_idle, clk, rst, done, !active)
  `ASSERT_IMPLIES(a_prod_reduced, clk, rst, done, acc < m)

endmodule

### sim/tb_miller_rabin_prime_test.sv
// testbench for the miller-rabin prime test: directed and random candidates against a local predictor
module tb_miller_rabin_prime_test;
  import mr_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 64'd200_000_000;
  localparam int SETTLE_CYCLES = 16;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] candidate;
  logic        done;
  logic        is_prime;

  // verdicts still owed by the block, oldest first
  bit          verdict_q[$];
  int          mismatches = 0;
  longint unsigned cycles = 0;
  int          gap_pct;

  miller_rabin_prime_test uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .candidate (candidate),
    .done      (done),
    .is_prime  (is_prime)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // exact modular product through a double-width intermediate
  function automatic word_t mulmod(input word_t a, input word_t b, input word_t m);
    logic [2*WORD_BITS-1:0] p;
    p = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
    return word_t'(p % {{WORD_BITS{1'b0}}, m});
  endfunction

  function automatic word_t powmod(input word_t a, input word_t e, input word_t m);
    word_t acc;
    word_t sq;
    acc = word_t'(1);
    sq  = a;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (e[i]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
    end
    return acc;
  endfunction

  // deterministic verdict with the twelve witness bases
  function automatic bit primality_of(input word_t n);
    word_t nm1, d, x, w;
    int    r;
    bit    comp;
    word_t witnesses[12];
    witnesses = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};
    if (n < 2) return 1'b0;
    nm1 = n - 1;
    d   = nm1;
    r   = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    foreach (witnesses[i]) begin
      w = witnesses[i];
      if (w == n) return 1'b1;
      x = powmod(w % n, d, n);
      if (x != 1 && x != nm1) begin
        comp = 1'b1;
        for (int j = 1; j < r; j++) begin
          x = mulmod(x, x, n);
          if (x == nm1) begin
            comp = 1'b0;
            break;
          end
        end
        if (comp) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input bit got, input bit want);
    $display("is_prime mismatch: got %0b, expected %0b", got, want);
    mismatches++;
  endtask

  // one transfer on the input side, preceded by an optional random idle stretch
  task automatic send_candidate(input word_t n);
    @(posedge clk);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      candidate <= {$urandom, $urandom};
      @(posedge clk);
    end
    start     <= 1'b1;
    candidate <= n;
    // busy read here is the value before the edge, so leaving the loop means accepted
    do @(posedge clk); while (busy);
    verdict_q.push_back(primality_of(n));
    start     <= 1'b0;
    candidate <= {$urandom, $urandom};
  endtask

  // result side: done marks a single-cycle transfer that cannot be held off
  always @(posedge clk) begin
    if (!rst && done) begin
      if (verdict_q.size() == 0) begin
        $display("result with no candidate outstanding: is_prime %0b", is_prime);
        mismatches++;
      end else begin
        if (is_prime !== verdict_q[0]) report_mismatch(is_prime, verdict_q[0]);
        void'(verdict_q.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("miller_rabin_prime_test: mismatch");
      $finish;
    end
  end

  // extremes, tiny values, the bases themselves, even values and strong pseudoprimes
  task automatic test_directed();
    word_t picks[$];
    picks = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd9, 64'd37, 64'd38, 64'd41,
              64'd561, 64'd2047, 64'd1373653, 64'd3215031751,
              64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
              64'hFFFF_FFFF_FFFF_FFC5,   // largest prime in the word
              64'h1FFF_FFFF_FFFF_FFFF,   // mersenne prime
              64'hFFFF_FFFF_FFFF_FFFE, 64'd3825123056546413051};
    foreach (picks[i]) send_candidate(picks[i]);
  endtask

  // mostly small candidates so primes stay cheap, with some wide ones mixed in
  task automatic test_random(input int count, input int idle_pct);
    word_t n;
    int    kind;
    gap_pct = idle_pct;
    repeat (count) begin
      kind = $urandom_range(99);
      if (kind < 60)      n = word_t'($urandom_range(4095));
      else if (kind < 80) n = word_t'($urandom_range(65535));
      else if (kind < 90) n = {$urandom, $urandom} & ~64'd1;   // wide even, cheap
      else if (kind < 96) n = {$urandom, $urandom} | 64'd1;    // wide odd
      else                n = word_t'($urandom_range(37));
      send_candidate(n);
    end
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    candidate  = '0;
    gap_pct    = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(34, 36);
    test_random(33, 55);
    test_random(33, 0);

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("miller_rabin_prime_test: match");
    end else begin
      $display("miller_rabin_prime_test: mismatch");
    end
    $finish;
  end

endmodule
